// ===== hdl/cpu6502_execute_unit_core_assert.svh =====
// ----------------------------------------------------------------------------
// cpu6502 execute unit assertion macros
// Concurrent check macros shared by the execute unit RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef CPU6502_EXECUTE_UNIT_CORE_ASSERT_SVH
`define CPU6502_EXECUTE_UNIT_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define CPU65_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cpu65 check failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define CPU65_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cpu65 check failed: next-cycle implication");

`else

`define CPU65_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CPU65_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/cpu65_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu65_pkg
// Shared types, operation codes and constants of the 6502 execute unit.
// ----------------------------------------------------------------------------
package cpu65_pkg;

	// operation codes
	typedef enum logic [5:0] {
		OP_ADC = 6'd0, OP_AND, OP_ASL, OP_BIT, OP_BPL, OP_BMI, OP_BVC, OP_BVS,
		OP_BCC, OP_BCS, OP_BNE, OP_BEQ, OP_BRK, OP_CMP, OP_CPX, OP_CPY,
		OP_DEC, OP_EOR, OP_CLC, OP_SEC, OP_CLI, OP_SEI, OP_CLV, OP_CLD,
		OP_SED, OP_INC, OP_JMP, OP_JSR, OP_LDA, OP_LDX, OP_LDY, OP_LSR,
		OP_NOP, OP_ORA, OP_TAX, OP_TXA, OP_DEX, OP_INX, OP_TAY, OP_TYA,
		OP_DEY, OP_INY, OP_ROL, OP_ROR, OP_RTI, OP_RTS, OP_SBC, OP_STA,
		OP_TXS, OP_TSX, OP_PHA, OP_PLA, OP_PHP, OP_PLP, OP_STX, OP_STY
	} op_t;

	// addressing modes
	localparam logic [3:0] AM_ABSOLUTE         = 4'd0;
	localparam logic [3:0] AM_ABSOLUTE_X       = 4'd1;
	localparam logic [3:0] AM_ABSOLUTE_Y       = 4'd2;
	localparam logic [3:0] AM_ACCUMULATOR      = 4'd3;
	localparam logic [3:0] AM_IMMEDIATE        = 4'd4;
	localparam logic [3:0] AM_INDIRECT         = 4'd5;
	localparam logic [3:0] AM_INDIRECT_X       = 4'd6;
	localparam logic [3:0] AM_INDEXED_ABSOLUTE = 4'd7;
	localparam logic [3:0] AM_INDIRECT_Y       = 4'd8;
	localparam logic [3:0] AM_ZERO_PAGE_X      = 4'd9;
	localparam logic [3:0] AM_ZERO_PAGE_Y      = 4'd10;
	localparam logic [3:0] AM_NONE             = 4'd11;
	localparam logic [3:0] AM_RELATIVE         = 4'd12;
	localparam logic [3:0] AM_ZERO_PAGE        = 4'd13;

	// status bit positions
	localparam int FLAG_N = 7;
	localparam int FLAG_V = 6;
	localparam int FLAG_B = 4;
	localparam int FLAG_D = 3;
	localparam int FLAG_I = 2;
	localparam int FLAG_Z = 1;
	localparam int FLAG_C = 0;

	localparam logic [7:0] FLAGS_RESET  = 8'h20;
	localparam logic [7:0] FLAGS_PUSH   = 8'h30;
	localparam logic [7:0] FLAGS_PULL_M = 8'hCF;
	localparam logic [7:0] SP_RESET     = 8'hFD;
	localparam logic [15:0] START_RESET = 16'hF000;

	// register index on the configuration port
	localparam logic REG_START_ADDRESS = 1'b0;

	// one input item
	typedef struct packed {
		logic [5:0]  mode;
		logic [3:0]  addr_mode;
		logic [7:0]  operand;
		logic [15:0] address;
	} instr_t;

	// one result item
	typedef struct packed {
		logic [15:0] next_pc;
		logic [7:0]  acc_out;
		logic [7:0]  x_out;
		logic [7:0]  y_out;
		logic [7:0]  status_out;
		logic [7:0]  sp_out;
		logic        mem_write;
		logic [15:0] write_address;
		logic [7:0]  write_data;
		logic        unknown_op;
	} result_t;

	// programmer-visible registers
	typedef struct packed {
		logic [15:0] pc;
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  p;
		logic [7:0]  sp;
	} arch_t;

	// stack pushes of one instruction: first at sp, second at sp-1
	typedef struct packed {
		logic       push_hi;
		logic       push_lo;
		logic [7:0] data_hi;
		logic [7:0] data_lo;
	} stk_wr_t;

	// instruction length per addressing mode
	function automatic logic [1:0] mode_len(input logic [3:0] am);
		logic [1:0] len;
		unique case (am)
			AM_ABSOLUTE, AM_ABSOLUTE_X, AM_ABSOLUTE_Y, AM_INDIRECT,
			AM_INDEXED_ABSOLUTE:                        len = 2'd3;
			AM_ACCUMULATOR, AM_NONE:                    len = 2'd1;
			AM_IMMEDIATE, AM_INDIRECT_X, AM_INDIRECT_Y, AM_ZERO_PAGE_X,
			AM_ZERO_PAGE_Y, AM_RELATIVE, AM_ZERO_PAGE:  len = 2'd2;
			default:                                    len = 2'd0;
		endcase
		return len;
	endfunction

endpackage

// ===== hdl/cpu65_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu65_stack
// Stack page split into four interleaved banks: one push pair written and
// the three bytes above the stack pointer read every cycle, with bypass.
// ----------------------------------------------------------------------------
module cpu65_stack #(
	parameter int STACK_DEPTH = 256
) (
	input  logic                clk,
	input  cpu65_pkg::stk_wr_t  wr,
	input  logic [7:0]          wr_sp,
	input  logic [7:0]          rd_sp,
	output logic [2:0][7:0]     pull_data
);

	localparam int AW   = $clog2(STACK_DEPTH);
	localparam int ROWS = STACK_DEPTH / 4;

	logic [7:0]      wr_sp_m1;
	logic [7:0]      rd_base;
	logic [AW-1:0]   wa_hi;
	logic [AW-1:0]   wa_lo;
	logic [3:0][7:0] bank_rd;
	logic [1:0]      sel_q;

	assign wr_sp_m1 = wr_sp - 8'd1;
	assign rd_base  = rd_sp + 8'd1;
	assign wa_hi    = wr_sp[AW-1:0];
	assign wa_lo    = wr_sp_m1[AW-1:0];

	// one bank per low address pair, reads the next four bytes above rd_sp
	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic [1:0] BANK = 2'(b);
		logic [1:0]    off;
		logic [7:0]    ra;
		logic [AW-3:0] rrow;
		logic          hit_hi;
		logic          hit_lo;
		logic          we;
		logic [AW-3:0] wrow;
		logic [7:0]    wd;
		logic [7:0]    rd_q;
		logic [7:0]    mem [ROWS];

		assign off    = BANK - rd_base[1:0];
		assign ra     = rd_base + {6'd0, off};
		assign rrow   = ra[AW-1:2];
		assign hit_hi = wr.push_hi && (wa_hi[1:0] == BANK);
		assign hit_lo = wr.push_lo && (wa_lo[1:0] == BANK);
		assign we     = hit_hi || hit_lo;
		assign wrow   = hit_hi ? wa_hi[AW-1:2] : wa_lo[AW-1:2];
		assign wd     = hit_hi ? wr.data_hi : wr.data_lo;

		// write port and registered read with write bypass
		always_ff @(posedge clk) begin
			if (we) begin
				mem[wrow] <= wd;
			end
			rd_q <= (we && (wrow == rrow)) ? wd : mem[rrow];
		end

		assign bank_rd[b] = rd_q;
	end

	// bank of sp+1 follows the pointer that the read was issued for
	always_ff @(posedge clk) begin
		sel_q <= rd_sp[1:0];
	end

	// pull bytes at sp+1, sp+2, sp+3
	for (genvar k = 0; k < 3; k++) begin : g_pull
		assign pull_data[k] = bank_rd[sel_q + 2'(k + 1)];
	end

endmodule

// ===== hdl/cpu65_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu65_exec
// Combinational execute logic: next register state, result item and stack
// pushes of one decoded instruction.
// ----------------------------------------------------------------------------
module cpu65_exec (
	input  cpu65_pkg::instr_t   instr,
	input  cpu65_pkg::arch_t    st,
	input  logic [2:0][7:0]     pull_data,
	output cpu65_pkg::arch_t    nxt,
	output cpu65_pkg::result_t  res,
	output cpu65_pkg::stk_wr_t  stk
);

	// N and Z from a value
	function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
		logic [7:0] q;
		q = p;
		q[cpu65_pkg::FLAG_N] = v[7];
		q[cpu65_pkg::FLAG_Z] = (v == 8'd0);
		return q;
	endfunction

	// flags of a compare
	function automatic logic [7:0] cmp_flags(input logic [7:0] p, input logic [7:0] r,
			input logic [7:0] v);
		logic [7:0] q;
		q = set_nz(p, r - v);
		q[cpu65_pkg::FLAG_C] = (r >= v);
		return q;
	endfunction

	// flags loaded from the stack keep B and force bit 5
	function automatic logic [7:0] pull_flags(input logic [7:0] p, input logic [7:0] v);
		logic [7:0] q;
		q = (v & cpu65_pkg::FLAGS_PULL_M) | cpu65_pkg::FLAGS_RESET;
		q[cpu65_pkg::FLAG_B] = p[cpu65_pkg::FLAG_B];
		return q;
	endfunction

	logic        acc_mode;
	logic [1:0]  len;
	logic [15:0] npc;
	logic [15:0] boff;
	logic [15:0] ret;
	logic [7:0]  addb;
	logic [8:0]  sum;
	logic [7:0]  src;
	logic        take;
	logic        wr;
	logic [7:0]  wdata;
	logic        unk;
	logic        sh_en;
	logic [7:0]  sh_r;
	logic        sh_c;

	assign acc_mode = (instr.addr_mode == cpu65_pkg::AM_ACCUMULATOR);
	assign len      = cpu65_pkg::mode_len(instr.addr_mode);
	assign boff     = {{8{instr.operand[7]}}, instr.operand};
	assign ret      = st.pc + 16'd2;
	assign src      = acc_mode ? st.a : instr.operand;

	// shared adder for ADC and SBC
	assign addb = (cpu65_pkg::op_t'(instr.mode) == cpu65_pkg::OP_SBC) ?
		~instr.operand : instr.operand;
	assign sum  = {1'b0, st.a} + {1'b0, addb} + {8'd0, st.p[cpu65_pkg::FLAG_C]};

	// operation decode and state update
	always_comb begin
		nxt   = st;
		npc   = st.pc + {14'd0, len};
		take  = 1'b0;
		wr    = 1'b0;
		wdata = 8'd0;
		unk   = 1'b0;
		sh_en = 1'b0;
		sh_r  = 8'd0;
		sh_c  = 1'b0;
		stk   = '0;
		unique case (cpu65_pkg::op_t'(instr.mode))
			cpu65_pkg::OP_ADC, cpu65_pkg::OP_SBC: begin
				nxt.a = sum[7:0];
				nxt.p = set_nz(st.p, sum[7:0]);
				nxt.p[cpu65_pkg::FLAG_V] = ~(st.a[7] ^ addb[7]) & (st.a[7] ^ sum[7]);
				nxt.p[cpu65_pkg::FLAG_C] = sum[8];
			end
			cpu65_pkg::OP_AND: begin
				nxt.a = st.a & instr.operand;
				nxt.p = set_nz(st.p, st.a & instr.operand);
			end
			cpu65_pkg::OP_ORA: begin
				nxt.a = st.a | instr.operand;
				nxt.p = set_nz(st.p, st.a | instr.operand);
			end
			cpu65_pkg::OP_EOR: begin
				nxt.a = st.a ^ instr.operand;
				nxt.p = set_nz(st.p, st.a ^ instr.operand);
			end
			cpu65_pkg::OP_ASL: begin
				sh_en = 1'b1;
				sh_r  = {src[6:0], 1'b0};
				sh_c  = src[7];
			end
			cpu65_pkg::OP_LSR: begin
				sh_en = 1'b1;
				sh_r  = {1'b0, src[7:1]};
				sh_c  = src[0];
			end
			cpu65_pkg::OP_ROL: begin
				sh_en = 1'b1;
				sh_r  = {src[6:0], st.p[cpu65_pkg::FLAG_C]};
				sh_c  = src[7];
			end
			cpu65_pkg::OP_ROR: begin
				sh_en = 1'b1;
				sh_r  = {st.p[cpu65_pkg::FLAG_C], src[7:1]};
				sh_c  = src[0];
			end
			cpu65_pkg::OP_BIT: begin
				nxt.p[cpu65_pkg::FLAG_N] = instr.operand[7];
				nxt.p[cpu65_pkg::FLAG_V] = instr.operand[6];
				nxt.p[cpu65_pkg::FLAG_Z] = ((instr.operand & st.a) == 8'd0);
			end
			cpu65_pkg::OP_BPL: take = !st.p[cpu65_pkg::FLAG_N];
			cpu65_pkg::OP_BMI: take = st.p[cpu65_pkg::FLAG_N];
			cpu65_pkg::OP_BVC: take = !st.p[cpu65_pkg::FLAG_V];
			cpu65_pkg::OP_BVS: take = st.p[cpu65_pkg::FLAG_V];
			cpu65_pkg::OP_BCC: take = !st.p[cpu65_pkg::FLAG_C];
			cpu65_pkg::OP_BCS: take = st.p[cpu65_pkg::FLAG_C];
			cpu65_pkg::OP_BNE: take = !st.p[cpu65_pkg::FLAG_Z];
			cpu65_pkg::OP_BEQ: take = st.p[cpu65_pkg::FLAG_Z];
			cpu65_pkg::OP_BRK: nxt.p[cpu65_pkg::FLAG_B] = 1'b1;
			cpu65_pkg::OP_CMP: nxt.p = cmp_flags(st.p, st.a, instr.operand);
			cpu65_pkg::OP_CPX: nxt.p = cmp_flags(st.p, st.x, instr.operand);
			cpu65_pkg::OP_CPY: nxt.p = cmp_flags(st.p, st.y, instr.operand);
			cpu65_pkg::OP_DEC: begin
				wr    = 1'b1;
				wdata = instr.operand - 8'd1;
				nxt.p = set_nz(st.p, instr.operand - 8'd1);
			end
			cpu65_pkg::OP_INC: begin
				wr    = 1'b1;
				wdata = instr.operand + 8'd1;
				nxt.p = set_nz(st.p, instr.operand + 8'd1);
			end
			cpu65_pkg::OP_CLC: nxt.p[cpu65_pkg::FLAG_C] = 1'b0;
			cpu65_pkg::OP_SEC: nxt.p[cpu65_pkg::FLAG_C] = 1'b1;
			cpu65_pkg::OP_CLI: nxt.p[cpu65_pkg::FLAG_I] = 1'b0;
			cpu65_pkg::OP_SEI: nxt.p[cpu65_pkg::FLAG_I] = 1'b1;
			cpu65_pkg::OP_CLV: nxt.p[cpu65_pkg::FLAG_V] = 1'b0;
			cpu65_pkg::OP_CLD: nxt.p[cpu65_pkg::FLAG_D] = 1'b0;
			cpu65_pkg::OP_SED: nxt.p[cpu65_pkg::FLAG_D] = 1'b1;
			cpu65_pkg::OP_JMP: npc = instr.address;
			cpu65_pkg::OP_JSR: begin
				stk.push_hi = 1'b1;
				stk.push_lo = 1'b1;
				stk.data_hi = ret[15:8];
				stk.data_lo = ret[7:0];
				nxt.sp      = st.sp - 8'd2;
				npc         = instr.address;
			end
			cpu65_pkg::OP_LDA: begin
				nxt.a = instr.operand;
				nxt.p = set_nz(st.p, instr.operand);
			end
			cpu65_pkg::OP_LDX: begin
				nxt.x = instr.operand;
				nxt.p = set_nz(st.p, instr.operand);
			end
			cpu65_pkg::OP_LDY: begin
				nxt.y = instr.operand;
				nxt.p = set_nz(st.p, instr.operand);
			end
			cpu65_pkg::OP_NOP: begin
			end
			cpu65_pkg::OP_TAX: begin
				nxt.x = st.a;
				nxt.p = set_nz(st.p, st.a);
			end
			cpu65_pkg::OP_TXA: begin
				nxt.a = st.x;
				nxt.p = set_nz(st.p, st.x);
			end
			cpu65_pkg::OP_DEX: begin
				nxt.x = st.x - 8'd1;
				nxt.p = set_nz(st.p, st.x - 8'd1);
			end
			cpu65_pkg::OP_INX: begin
				nxt.x = st.x + 8'd1;
				nxt.p = set_nz(st.p, st.x + 8'd1);
			end
			cpu65_pkg::OP_TAY: begin
				nxt.y = st.a;
				nxt.p = set_nz(st.p, st.a);
			end
			cpu65_pkg::OP_TYA: begin
				nxt.a = st.y;
				nxt.p = set_nz(st.p, st.y);
			end
			cpu65_pkg::OP_DEY: begin
				nxt.y = st.y - 8'd1;
				nxt.p = set_nz(st.p, st.y - 8'd1);
			end
			cpu65_pkg::OP_INY: begin
				nxt.y = st.y + 8'd1;
				nxt.p = set_nz(st.p, st.y + 8'd1);
			end
			cpu65_pkg::OP_RTI: begin
				nxt.p  = pull_flags(st.p, pull_data[0]);
				nxt.sp = st.sp + 8'd3;
				npc    = {pull_data[2], pull_data[1]};
			end
			cpu65_pkg::OP_RTS: begin
				nxt.sp = st.sp + 8'd2;
				npc    = {pull_data[1], pull_data[0]} + 16'd1;
			end
			cpu65_pkg::OP_STA: begin
				wr    = 1'b1;
				wdata = st.a;
			end
			cpu65_pkg::OP_STX: begin
				wr    = 1'b1;
				wdata = st.x;
			end
			cpu65_pkg::OP_STY: begin
				wr    = 1'b1;
				wdata = st.y;
			end
			cpu65_pkg::OP_TXS: nxt.sp = st.x;
			cpu65_pkg::OP_TSX: begin
				nxt.x = st.sp;
				nxt.p = set_nz(st.p, st.sp);
			end
			cpu65_pkg::OP_PHA: begin
				stk.push_hi = 1'b1;
				stk.data_hi = st.a;
				nxt.sp      = st.sp - 8'd1;
			end
			cpu65_pkg::OP_PHP: begin
				stk.push_hi = 1'b1;
				stk.data_hi = st.p | cpu65_pkg::FLAGS_PUSH;
				nxt.sp      = st.sp - 8'd1;
			end
			cpu65_pkg::OP_PLA: begin
				nxt.a  = pull_data[0];
				nxt.p  = set_nz(st.p, pull_data[0]);
				nxt.sp = st.sp + 8'd1;
			end
			cpu65_pkg::OP_PLP: begin
				nxt.p  = pull_flags(st.p, pull_data[0]);
				nxt.sp = st.sp + 8'd1;
			end
			default: begin
				unk = 1'b1;
				npc = st.pc;
			end
		endcase

		// shifts and rotates: accumulator or memory target
		if (sh_en) begin
			nxt.p = set_nz(st.p, sh_r);
			nxt.p[cpu65_pkg::FLAG_C] = sh_c;
			if (acc_mode) begin
				nxt.a = sh_r;
			end else begin
				wr    = 1'b1;
				wdata = sh_r;
			end
		end

		// taken branch adds the signed offset
		if (take) begin
			npc = npc + boff;
		end
		nxt.pc = npc;
	end

	// result item
	always_comb begin
		res.next_pc       = nxt.pc;
		res.acc_out       = nxt.a;
		res.x_out         = nxt.x;
		res.y_out         = nxt.y;
		res.status_out    = nxt.p;
		res.sp_out        = nxt.sp;
		res.mem_write     = wr;
		res.write_address = wr ? instr.address : 16'd0;
		res.write_data    = wr ? wdata : 8'd0;
		res.unknown_op    = unk;
	end

endmodule

// ===== hdl/cpu6502_execute_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu6502_execute_unit_core
// Executes one decoded 6502 instruction per item: A, X, Y, flags, stack
// pointer, program counter and an internal stack page, one result per item.
// ----------------------------------------------------------------------------
// An instruction item is taken into an input register and executed from
// there into the result register, so a new item is accepted every clock
// cycle while res_stall does not hold the result. The one-cycle rate is
// set by the register file loop: each instruction reads the A, X, Y, flags,
// stack pointer and program counter left by the one before. Stack pulls read
// the stack page, which is kept in four interleaved banks that always hold
// the three bytes above the stack pointer ready, so RTI, RTS and the pulls
// run at the same rate. The start address register loads the program
// counter when written; write it only while no item is in flight.
`include "cpu6502_execute_unit_core_assert.svh"

module cpu6502_execute_unit_core #(
	parameter int STACK_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	// instruction items
	input  logic                instr_valid,
	output logic                instr_stall,
	input  cpu65_pkg::instr_t   instr,
	// result items
	output logic                res_valid,
	input  logic                res_stall,
	output cpu65_pkg::result_t  res,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic                s1_valid_q;
	cpu65_pkg::instr_t   s1_q;
	cpu65_pkg::arch_t    arch_q;
	logic [15:0]         start_q;
	logic                res_valid_q;
	cpu65_pkg::result_t  res_q;
	cpu65_pkg::arch_t    nxt;
	cpu65_pkg::result_t  nxt_res;
	cpu65_pkg::stk_wr_t  stk;
	cpu65_pkg::stk_wr_t  stk_fire;
	logic [2:0][7:0]     pull_data;
	logic [7:0]          rd_sp;
	logic                fire;
	logic                in_take;
	logic                cfg_wr;

	// handshake
	assign fire        = s1_valid_q && (!res_valid_q || !res_stall);
	assign instr_stall = s1_valid_q && !fire;
	assign in_take     = instr_valid && !instr_stall;
	assign res_valid   = res_valid_q;
	assign res         = res_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[2] == cpu65_pkg::REG_START_ADDRESS);
	assign prdata = (paddr[2] == cpu65_pkg::REG_START_ADDRESS) ? {16'd0, start_q} : 32'd0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_take) begin
			s1_valid_q <= 1'b1;
		end else if (fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			s1_q <= instr;
		end
	end

	// execute logic
	cpu65_exec u_exec (
		.instr     (s1_q),
		.st        (arch_q),
		.pull_data (pull_data),
		.nxt       (nxt),
		.res       (nxt_res),
		.stk       (stk)
	);

	// stack page, pushes only on an executed item
	always_comb begin
		stk_fire         = stk;
		stk_fire.push_hi = stk.push_hi && fire;
		stk_fire.push_lo = stk.push_lo && fire;
	end

	assign rd_sp = fire ? nxt.sp : arch_q.sp;

	cpu65_stack #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_stack (
		.clk       (clk),
		.wr        (stk_fire),
		.wr_sp     (arch_q.sp),
		.rd_sp     (rd_sp),
		.pull_data (pull_data)
	);

	// register file and start address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= cpu65_pkg::START_RESET;
			arch_q.pc <= cpu65_pkg::START_RESET;
			arch_q.a  <= 8'd0;
			arch_q.x  <= 8'd0;
			arch_q.y  <= 8'd0;
			arch_q.p  <= cpu65_pkg::FLAGS_RESET;
			arch_q.sp <= cpu65_pkg::SP_RESET;
		end else if (cfg_wr) begin
			start_q   <= pwdata[15:0];
			arch_q.pc <= pwdata[15:0];
		end else if (fire) begin
			arch_q <= nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= nxt_res;
		end
	end

	// checks
	`CPU65_ASSERT_NEXT(a_fire_gives_result, clk, arst_n, fire, res_valid_q)
	`CPU65_ASSERT_NEXT(a_sp_holds_idle, clk, arst_n, !fire, $stable(arch_q.sp))
	`CPU65_ASSERT_NEXT(a_unknown_keeps_state, clk, arst_n, fire && nxt_res.unknown_op && !cfg_wr, $stable(arch_q))
	`CPU65_ASSERT_IMPLY(a_no_write_zero, clk, arst_n, res_valid_q && !res_q.mem_write, (res_q.write_address == 16'd0) && (res_q.write_data == 8'd0))
	`CPU65_ASSERT_IMPLY(a_result_matches_state, clk, arst_n, res_valid_q && !s1_valid_q, (res_q.sp_out == arch_q.sp) && (res_q.acc_out == arch_q.a))

endmodule
